>>> hdl/bmsrfd_pkg.sv
// ----------------------------------------------------------------------------
// bmsrfd_pkg
// Shared types and constants of the battery monitor reply frame decoder.
// ----------------------------------------------------------------------------
package bmsrfd_pkg;

  localparam int unsigned FrameBytes    = 13;
  localparam int unsigned CellsPerFrame = 3;
  localparam int unsigned MaxFrames     = 16;

  // Request command codes.
  localparam logic [2:0] CMD_PACK   = 3'd0;
  localparam logic [2:0] CMD_MINMAX = 3'd1;
  localparam logic [2:0] CMD_TEMP   = 3'd2;
  localparam logic [2:0] CMD_MOS    = 3'd3;
  localparam logic [2:0] CMD_STATUS = 3'd4;
  localparam logic [2:0] CMD_CELLS  = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CHECKSUM  = 3'd1;
  localparam logic [2:0] ST_NO_DATA   = 3'd2;
  localparam logic [2:0] ST_SLEEPING  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_BAD_CELLS = 3'd5;

  // Configuration register indexes.
  localparam logic REG_MIN_CELLS = 1'b0;
  localparam logic REG_MAX_CELLS = 1'b1;

  localparam logic [15:0] CurrentOffset = 16'd30000;
  localparam logic [7:0]  SleepAddr     = 8'h20;
  localparam logic [15:0] MaxSoc        = 16'd1000;
  localparam logic [8:0]  TempOffset2   = 9'd80;

  // Word handed from the framing front end to the decode back end.
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  cmd;
    logic [3:0]  fnum;
    logic        last;
    logic [7:0]  cell_count;
    logic [12:0][7:0] bytes;
  } frame_t;

  // Decoded result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  command_code;
    logic [3:0]  frame_number;
    logic        last_frame;
    logic [31:0] wide_value;
    logic [16:0] signed_value;
    logic [15:0] value_one;
    logic [15:0] value_two;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [1:0]  switch_flags;
  } result_t;

endpackage

>>> hdl/bmsrfd_front.sv
// ----------------------------------------------------------------------------
// bmsrfd_front
// Gathers bytes into frames, checks the sum and address, sizes replies.
// ----------------------------------------------------------------------------
module bmsrfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [2:0]          request_command_i,
  input  logic                start_of_reply_i,
  input  logic [5:0]          min_cells_i,
  input  logic [5:0]          max_cells_i,
  input  logic                cnt_we_i,
  input  logic [7:0]          cnt_val_i,
  output logic                frame_valid_o,
  output bmsrfd_pkg::frame_t  frame_o
);
  import bmsrfd_pkg::*;

  logic [7:0]  store_q [FrameBytes];
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  sum_q, sum_d;
  logic        abort_q, abort_d;
  logic [4:0]  fexp_q, fexp_d;
  logic [7:0]  cells_q;
  logic        take, count_ok, bad_start, done, last;
  logic [3:0]  pos_eff;
  logic [15:0] nfr_prod;
  logic [6:0]  nfr;
  logic [2:0]  st;

  // Cell count as the front sees it, including a status reply just decoded.
  logic [7:0] cells_now;
  assign cells_now = cnt_we_i ? cnt_val_i : cells_q;

  assign count_ok = (cells_now != 8'd0) && (cells_now >= {2'b0, min_cells_i})
                  && (cells_now < {2'b0, max_cells_i});
  assign bad_start = valid_i && start_of_reply_i && (request_command_i == CMD_CELLS)
                   && !count_ok;
  assign take    = valid_i && (start_of_reply_i || !abort_q) && !bad_start;
  assign pos_eff = start_of_reply_i ? 4'd0 : pos_q;
  assign done    = take && (pos_eff == 4'(FrameBytes - 1));

  // Frames for a cell reply, rounded up. The divide by three is a multiply
  // by 171 and a shift by 9, exact for every value below 512.
  assign nfr_prod = (16'(cells_now) + 16'(CellsPerFrame - 1)) * 16'd171;
  assign nfr      = nfr_prod[15:9];

  // Frame checks and next state.
  always_comb begin
    logic [7:0] s0;
    logic [4:0] fe;
    logic [3:0] fc;
    s0 = start_of_reply_i ? 8'd0 : sum_q;
    fc = start_of_reply_i ? 4'd0 : fcnt_q;
    fe = fexp_q;
    if (valid_i && start_of_reply_i) begin
      if (request_command_i == CMD_CELLS) begin
        fe = (nfr > 7'(MaxFrames)) ? 5'(MaxFrames) : nfr[4:0];
      end else begin
        fe = 5'd1;
      end
    end
    if (s0 != rx_byte_i) st = ST_CHECKSUM;
    else if (s0 == 8'd0) st = ST_NO_DATA;
    else if (store_q[1] >= SleepAddr && !(start_of_reply_i)) st = ST_SLEEPING;
    else st = ST_OK;
    last   = (st != ST_OK) || ({1'b0, fc} + 5'd1 >= fe);
    pos_d  = pos_q;
    sum_d  = sum_q;
    fcnt_d = fcnt_q;
    abort_d = abort_q;
    fexp_d = fe;
    if (bad_start) begin
      abort_d = 1'b1;
      fexp_d  = 5'd0;
    end else if (take) begin
      abort_d = 1'b0;
      if (done) begin
        pos_d  = 4'd0;
        sum_d  = 8'd0;
        fcnt_d = fc + 4'd1;
        if (last) abort_d = 1'b1;
      end else begin
        pos_d  = pos_eff + 4'd1;
        sum_d  = s0 + rx_byte_i;
        fcnt_d = fc;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 4'd0;
      fcnt_q  <= 4'd0;
      sum_q   <= 8'd0;
      abort_q <= 1'b1;
      fexp_q  <= 5'd0;
      cells_q <= 8'd0;
    end else begin
      pos_q   <= pos_d;
      fcnt_q  <= fcnt_d;
      sum_q   <= sum_d;
      abort_q <= abort_d;
      fexp_q  <= fexp_d;
      cells_q <= cells_now;
    end
  end

  // Frame byte store.
  always_ff @(posedge clk_i) begin
    if (take) store_q[pos_eff] <= rx_byte_i;
  end

  // Hand a finished frame or a refused start to the back end.
  always_comb begin
    frame_valid_o = bad_start || done;
    frame_o.cmd   = request_command_i;
    frame_o.fnum  = start_of_reply_i ? 4'd0 : fcnt_q;
    frame_o.cell_count = cells_now;
    for (int i = 0; i < FrameBytes - 1; i++) frame_o.bytes[i] = store_q[i];
    frame_o.bytes[FrameBytes - 1] = rx_byte_i;
    if (bad_start) begin
      frame_o.status = ST_BAD_CELLS;
      frame_o.last   = 1'b1;
    end else begin
      frame_o.status = st;
      frame_o.last   = last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(bad_start && take))
    else $error("refused start also taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done |-> (pos_eff == 4'(FrameBytes - 1)))
    else $error("frame end off position");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q < 4'(FrameBytes))
    else $error("byte position overrun");

endmodule

>>> hdl/bmsrfd_back.sv
// ----------------------------------------------------------------------------
// bmsrfd_back
// Decodes a checked frame into result fields for the pending command.
// ----------------------------------------------------------------------------
module bmsrfd_back (
  input  bmsrfd_pkg::frame_t  frame_i,
  output bmsrfd_pkg::result_t result_o,
  output logic                cnt_we_o,
  output logic [7:0]          cnt_val_o
);
  import bmsrfd_pkg::*;

  always_comb begin
    logic [15:0] a45, a78, a89, a910, a1011, a56;
    logic [16:0] diff;
    logic signed [9:0] s;
    logic signed [9:0] t;
    logic [7:0] base, left, k;
    logic [2:0] st;
    a45   = {frame_i.bytes[4], frame_i.bytes[5]};
    a56   = {frame_i.bytes[5], frame_i.bytes[6]};
    a78   = {frame_i.bytes[7], frame_i.bytes[8]};
    a89   = {frame_i.bytes[8], frame_i.bytes[9]};
    a910  = {frame_i.bytes[9], frame_i.bytes[10]};
    a1011 = {frame_i.bytes[10], frame_i.bytes[11]};
    diff  = 17'd0;
    s     = 10'(frame_i.bytes[4]) + 10'(frame_i.bytes[6]) - 10'(TempOffset2);
    t     = (s < 0) ? -((-s) >>> 1) : (s >>> 1);
    base  = 8'(frame_i.fnum) * 8'(CellsPerFrame);
    left  = (frame_i.cell_count > base) ? frame_i.cell_count - base : 8'd0;
    k     = (left > 8'(CellsPerFrame)) ? 8'(CellsPerFrame) : left;
    st    = frame_i.status;
    result_o = '0;
    cnt_we_o = 1'b0;
    cnt_val_o = frame_i.bytes[4];
    if (st == ST_OK) begin
      case (frame_i.cmd)
        CMD_PACK: begin
          if (a89 == 16'd0 || a1011 > MaxSoc) begin
            st = ST_RANGE;
          end else begin
            result_o.signed_value = {1'b0, a89} - {1'b0, CurrentOffset};
            result_o.value_one = a45;
            result_o.value_two = a1011;
          end
        end
        CMD_MINMAX: begin
          diff = {1'b0, a45} - {1'b0, a78};
          result_o.signed_value = diff;
          result_o.value_one = a45;
          result_o.value_two = a78;
          result_o.byte_one = frame_i.bytes[6];
          result_o.byte_two = frame_i.bytes[9];
        end
        CMD_TEMP: result_o.signed_value = 17'(t);
        CMD_MOS: begin
          result_o.wide_value = {frame_i.bytes[8], frame_i.bytes[9],
                                 frame_i.bytes[10], frame_i.bytes[11]};
          result_o.byte_one = frame_i.bytes[4];
          result_o.byte_two = frame_i.bytes[7];
          result_o.switch_flags = {frame_i.bytes[6] == 8'd0, frame_i.bytes[5] == 8'd0};
        end
        CMD_STATUS: begin
          cnt_we_o = 1'b1;
          result_o.value_one = a910;
          result_o.value_two = {8'd0, frame_i.bytes[7]};
          result_o.byte_one = frame_i.bytes[4];
          result_o.byte_two = frame_i.bytes[5];
          result_o.byte_three = frame_i.bytes[6];
        end
        CMD_CELLS: begin
          result_o.byte_one = base;
          result_o.byte_two = k;
          if (k > 8'd0) result_o.value_one = a56;
          if (k > 8'd1) result_o.value_two = a78;
          if (k > 8'd2) result_o.wide_value = {16'd0, a910};
        end
        default: ;
      endcase
    end
    if (st != ST_OK) begin
      result_o = '0;
      result_o.last_frame = 1'b1;
    end else begin
      result_o.last_frame = frame_i.last;
    end
    result_o.status = st;
    result_o.command_code = frame_i.cmd;
    result_o.frame_number = frame_i.fnum;
  end

endmodule

>>> hdl/bmsrfd_fifo.sv
// ----------------------------------------------------------------------------
// bmsrfd_fifo
// Short result queue between the decoder and the output side.
// ----------------------------------------------------------------------------
module bmsrfd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmsrfd_pkg::result_t data_i,
  input  logic                pop_i,
  output bmsrfd_pkg::result_t data_o,
  output logic                empty_o,
  output logic                full_o
);
  import bmsrfd_pkg::*;

  result_t     mem_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        do_pop, do_push;

  assign empty_o = (cnt_q == 3'd0);
  assign full_o  = (cnt_q == 3'd4);
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i;
  assign data_o  = mem_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (do_push) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o && !do_pop))
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("fill count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (wp_q - rp_q) == cnt_q[1:0])
    else $error("pointers disagree with fill count");

endmodule

>>> hdl/bms_response_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// bms_response_frame_decoder_core
// Battery monitor reply decoder: bytes in, one decoded word per frame out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Payload
// input     in         push/full      rx_byte, request_command, start_of_reply
// result    out        empty/pop      status ... switch_flags
// config    in         cfg_we_i       cfg_index_i, cfg_data_i
//
// One byte is taken each cycle while full is low; the decode adds no stall.
// Once its frame's last byte is taken, a word passes into the stage register and
// then into the result queue before it is on the result ports.
// full rises when the four-word result queue cannot take a possible word.
// Reset is asynchronous; the block starts idle awaiting a reply start.
module bms_response_frame_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic [2:0]  request_command_i,
  input  logic        start_of_reply_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [2:0]  command_code_o,
  output logic [3:0]  frame_number_o,
  output logic        last_frame_o,
  output logic [31:0] wide_value_o,
  output logic [16:0] signed_value_o,
  output logic [15:0] value_one_o,
  output logic [15:0] value_two_o,
  output logic [7:0]  byte_one_o,
  output logic [7:0]  byte_two_o,
  output logic [7:0]  byte_three_o,
  output logic [1:0]  switch_flags_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import bmsrfd_pkg::*;

  logic [5:0] min_q, max_q;
  logic       fv_q, fv, cnt_we;
  frame_t     fr, fr_q;
  result_t    res, q_out;
  logic [7:0] cnt_val;
  logic       q_full, q_empty;
  logic       occ3;
  logic [2:0] occ_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 6'd1;
      max_q <= 6'd48;
    end else if (cfg_we_i && cfg_index_i[1] == 1'b0) begin
      if (cfg_index_i[0] == REG_MIN_CELLS) min_q <= cfg_data_i;
      else max_q <= cfg_data_i;
    end
  end

  bmsrfd_front u_front (
    .clk_i, .rst_ni, .valid_i(push && !full), .rx_byte_i, .request_command_i,
    .start_of_reply_i, .min_cells_i(min_q), .max_cells_i(max_q),
    .cnt_we_i(fv_q && cnt_we), .cnt_val_i(cnt_val),
    .frame_valid_o(fv), .frame_o(fr));

  // Stage register between framing and decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else fv_q <= fv;
  end
  always_ff @(posedge clk_i) begin
    if (fv) fr_q <= fr;
  end

  bmsrfd_back u_back (.frame_i(fr_q), .result_o(res), .cnt_we_o(cnt_we),
                      .cnt_val_o(cnt_val));

  bmsrfd_fifo u_fifo (.clk_i, .rst_ni, .push_i(fv_q), .data_i(res), .pop_i(pop),
                      .data_o(q_out), .empty_o(q_empty), .full_o(q_full));

  // Keep room for the word in the stage register plus one new one.
  assign full  = q_full || (fv_q && !(pop && !q_empty) && occ3);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) occ_q <= 3'd0;
    else occ_q <= occ_q + 3'(fv_q) - 3'(pop && !q_empty);
  end
  assign occ3 = (occ_q >= 3'd3);

  assign empty          = q_empty;
  assign status_o       = q_out.status;
  assign command_code_o = q_out.command_code;
  assign frame_number_o = q_out.frame_number;
  assign last_frame_o   = q_out.last_frame;
  assign wide_value_o   = q_out.wide_value;
  assign signed_value_o = q_out.signed_value;
  assign value_one_o    = q_out.value_one;
  assign value_two_o    = q_out.value_two;
  assign byte_one_o     = q_out.byte_one;
  assign byte_two_o     = q_out.byte_two;
  assign byte_three_o   = q_out.byte_three;
  assign switch_flags_o = q_out.switch_flags;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fv_q && q_full))
    else $error("decoded word lost at full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= 3'd4)
    else $error("occupancy out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (occ_q == 3'd0) == q_empty)
    else $error("occupancy disagrees with queue");

endmodule
